// ----- sv/suvar_pkg.sv -----
// Shared types and constants for the smoothed unit-vector axis remap block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package suvar_pkg;

	localparam int unsigned ONE_Q16  = 65536;
	localparam int unsigned UNIT_ONE = 16384;

	// Register indexes of the configuration port.
	localparam logic REG_SMOOTH = 1'b0;
	localparam logic REG_COORD  = 1'b1;

	// Coordinate-system codes; any other code maps as identity.
	localparam logic [1:0] CS_IDENTITY = 2'd0;
	localparam logic [1:0] CS_BASIC    = 2'd1;
	localparam logic [1:0] CS_TILT     = 2'd2;

	typedef struct packed {
		logic       load;
		logic       filt_mul;
		logic       filt_acc;
		logic [1:0] axis;
		logic       norm_init;
		logic       shift;
		logic       sq;
		logic       sqrt_step;
		logic       div_init;
		logic       div_step;
		logic       div_store;
		logic       out_load;
	} suvar_cmd_t;

	typedef struct packed {
		logic zero;
		logic normed;
	} suvar_stat_t;

endpackage
`default_nettype wire

// ----- sv/smoothed_unit_vector_axis_remap_unit.sv -----
// One request is a three-axis sample; it passes through a low-pass filter per
// axis and is normalised to a Q1.14 unit vector, then remapped by the
// coordinate-system register. Each item steps through the shared filter
// multipliers, the one-bit normalising shift, the squaring multiplier, the
// bitwise square root and the three-lane divider. An all-zero filtered
// vector skips normalisation. The next request is taken while the previous
// result still waits in the output register.
`default_nettype none
module smoothed_unit_vector_axis_remap_unit
	import suvar_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire         [16:0] cfg_wdata,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire signed  [15:0] sample_x,
	input  wire signed  [15:0] sample_y,
	input  wire signed  [15:0] sample_z,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [15:0] coord_x,
	output logic signed [15:0] coord_y,
	output logic signed [15:0] coord_z
);

	logic [16:0] smoothing_factor_q;
	logic [1:0]  coordinate_system_q;
	suvar_cmd_t  cmd;
	suvar_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothing_factor_q  <= 17'(ONE_Q16);
			coordinate_system_q <= CS_IDENTITY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SMOOTH: smoothing_factor_q  <= cfg_wdata;
				REG_COORD:  coordinate_system_q <= cfg_wdata[1:0];
				default: begin
				end
			endcase
		end
	end

	suvar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	suvar_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.smoothing_factor  (smoothing_factor_q),
		.coordinate_system (coordinate_system_q),
		.sample_x          (sample_x),
		.sample_y          (sample_y),
		.sample_z          (sample_z),
		.coord_x           (coord_x),
		.coord_y           (coord_y),
		.coord_z           (coord_z)
	);

	// The block works on one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> coord_x >= -16'sd16384 && coord_x <= 16'sd16384 &&
			coord_y >= -16'sd16384 && coord_y <= 16'sd16384 &&
			coord_z >= -16'sd16384 && coord_z <= 16'sd16384)
		else $error("unit vector component out of range");

endmodule
`default_nettype wire

// ----- sv/suvar_ctrl.sv -----
// Sequencing state machine for the smoothed unit-vector axis remap block.
// Depends on suvar_pkg for the command and status structs.
`default_nettype none
module suvar_ctrl
	import suvar_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  wire         out_ready,
	input  suvar_stat_t stat,
	output suvar_cmd_t  cmd
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_FMUL  = 10'b0000000010,
		ST_FACC  = 10'b0000000100,
		ST_NINIT = 10'b0000001000,
		ST_SHIFT = 10'b0000010000,
		ST_SQ    = 10'b0000100000,
		ST_SQRT  = 10'b0001000000,
		ST_DIVI  = 10'b0010000000,
		ST_DIV   = 10'b0100000000,
		ST_DONE  = 10'b1000000000
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.axis = cnt_q[1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_FMUL;
				end
			end
			ST_FMUL: begin
				cmd.filt_mul = 1'b1;
				state_d      = ST_FACC;
			end
			ST_FACC: begin
				cmd.filt_acc = 1'b1;
				if (cnt_q == 5'd2) begin
					cnt_d   = '0;
					state_d = ST_NINIT;
				end else begin
					cnt_d   = cnt_q + 5'd1;
					state_d = ST_FMUL;
				end
			end
			ST_NINIT: begin
				cmd.norm_init = 1'b1;
				state_d       = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (stat.zero) begin
					state_d = ST_DONE;
				end else if (stat.normed) begin
					cnt_d   = '0;
					state_d = ST_SQ;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			ST_SQ: begin
				cmd.sq = 1'b1;
				if (cnt_q == 5'd2) begin
					cnt_d   = '0;
					state_d = ST_SQRT;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					state_d = ST_DIVI;
				end
			end
			ST_DIVI: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 5'd14) begin
					cmd.div_store = 1'b1;
					state_d       = ST_DONE;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/suvar_dp.sv -----
// Datapath: low-pass filters, normalising shift, sum of squares, bitwise
// square root, three-lane restoring divider and output remap. Uses suvar_pkg.
`default_nettype none
module suvar_dp
	import suvar_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  suvar_cmd_t         cmd,
	output suvar_stat_t        stat,
	input  wire         [16:0] smoothing_factor,
	input  wire         [1:0]  coordinate_system,
	input  wire signed  [15:0] sample_x,
	input  wire signed  [15:0] sample_y,
	input  wire signed  [15:0] sample_z,
	output logic signed [15:0] coord_x,
	output logic signed [15:0] coord_y,
	output logic signed [15:0] coord_z
);

	localparam int P1_W  = 34;
	localparam int P2_W  = 50;
	localparam int ACC_W = ((P1_W + FRAC_BITS > P2_W) ? P1_W + FRAC_BITS : P2_W) + 1;
	localparam int R_W   = ACC_W - 16;

	logic signed [15:0] samp_q [3];
	logic signed [31:0] filt_q [3];
	logic signed [15:0] unit_q [3];
	logic        [31:0] mag_q  [3];
	logic        [31:0] max_q;
	logic signed [P1_W-1:0] p1_q;
	logic signed [P2_W-1:0] p2_q;
	logic        [63:0] sum_q, res_q, bit_q;
	logic        [31:0] rem_q  [3];
	logic        [14:0] nlow_q [3];
	logic        [13:0] quo_q  [3];

	logic        [16:0] a_sat;
	logic signed [17:0] a_s, b_s;
	logic signed [ACC_W-1:0] acc;
	logic signed [R_W-1:0]   r;
	logic signed [31:0] r_sat;
	logic        [63:0] sqv;
	logic        [63:0] trial;
	logic        [31:0] norm;

	assign a_sat = (smoothing_factor > 17'(ONE_Q16)) ? 17'(ONE_Q16) : smoothing_factor;
	assign a_s   = $signed({1'b0, a_sat});
	assign b_s   = $signed(18'(ONE_Q16)) - a_s;

	// Half-up rounding of the weighted sum, then clamp to 32 bits.
	assign acc = ($signed(ACC_W'(p1_q)) <<< FRAC_BITS) + $signed(ACC_W'(p2_q));
	assign r   = R_W'((acc + $signed(ACC_W'(32768))) >>> 16);
	always_comb begin
		if (r > $signed(R_W'(32'sh7fffffff))) begin
			r_sat = 32'sh7fffffff;
		end else if (r < -$signed(R_W'(33'sh080000000))) begin
			r_sat = 32'sh80000000;
		end else begin
			r_sat = 32'(r);
		end
	end

	assign sqv   = mag_q[cmd.axis] * mag_q[cmd.axis];
	assign trial = res_q + bit_q;
	assign norm  = res_q[31:0];

	assign stat.zero   = (max_q == 32'd0);
	assign stat.normed = max_q[31] | max_q[30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				filt_q[i] <= '0;
				unit_q[i] <= '0;
			end
		end else begin
			if (cmd.filt_acc) begin
				filt_q[cmd.axis] <= r_sat;
			end
			if (cmd.div_store) begin
				for (int i = 0; i < 3; i++) begin
					logic [14:0] u;
					logic        q0;
					q0 = ({rem_q[i], nlow_q[i][14]} >= {1'b0, norm});
					u  = {quo_q[i], q0};
					if (u > 15'(UNIT_ONE)) begin
						u = 15'(UNIT_ONE);
					end
					unit_q[i] <= filt_q[i][31] ? -$signed({1'b0, u}) : $signed({1'b0, u});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			samp_q[0] <= sample_x;
			samp_q[1] <= sample_y;
			samp_q[2] <= sample_z;
		end
		if (cmd.filt_mul) begin
			p1_q <= P1_W'(a_s * samp_q[cmd.axis]);
			p2_q <= P2_W'(b_s * filt_q[cmd.axis]);
		end
		if (cmd.norm_init) begin
			logic [31:0] m0, m1, m2, mx;
			m0 = filt_q[0][31] ? 32'(-filt_q[0]) : 32'(filt_q[0]);
			m1 = filt_q[1][31] ? 32'(-filt_q[1]) : 32'(filt_q[1]);
			m2 = filt_q[2][31] ? 32'(-filt_q[2]) : 32'(filt_q[2]);
			mx = (m0 > m1) ? m0 : m1;
			mx = (m2 > mx) ? m2 : mx;
			mag_q[0] <= m0;
			mag_q[1] <= m1;
			mag_q[2] <= m2;
			max_q    <= mx;
			sum_q    <= '0;
			res_q    <= '0;
			bit_q    <= 64'd1 << 62;
		end
		if (cmd.shift) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= mag_q[i] << 1;
			end
			max_q <= max_q << 1;
		end
		if (cmd.sq) begin
			sum_q <= sum_q + sqv;
		end
		if (cmd.sqrt_step) begin
			if (sum_q >= trial) begin
				sum_q <= sum_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.div_init) begin
			for (int i = 0; i < 3; i++) begin
				logic [46:0] n;
				n = {1'b0, mag_q[i], 14'd0} + 47'(norm[31:1]);
				rem_q[i]  <= n[46:15];
				nlow_q[i] <= n[14:0];
				quo_q[i]  <= '0;
			end
		end
		if (cmd.div_step && !cmd.div_store) begin
			for (int i = 0; i < 3; i++) begin
				logic [32:0] r2;
				r2 = {rem_q[i], nlow_q[i][14]};
				if (r2 >= {1'b0, norm}) begin
					rem_q[i] <= 32'(r2 - {1'b0, norm});
					quo_q[i] <= {quo_q[i][12:0], 1'b1};
				end else begin
					rem_q[i] <= r2[31:0];
					quo_q[i] <= {quo_q[i][12:0], 1'b0};
				end
				nlow_q[i] <= nlow_q[i] << 1;
			end
		end
		if (cmd.out_load) begin
			case (coordinate_system)
				CS_BASIC: begin
					coord_x <= unit_q[1];
					coord_y <= unit_q[0];
					coord_z <= -unit_q[2];
				end
				CS_TILT: begin
					coord_x <= unit_q[2];
					coord_y <= unit_q[0];
					coord_z <= unit_q[1];
				end
				default: begin
					coord_x <= unit_q[0];
					coord_y <= unit_q[1];
					coord_z <= unit_q[2];
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- dv/smoothed_unit_vector_axis_remap_unit_tb.sv -----
// Self-checking testbench for smoothed_unit_vector_axis_remap_unit.
// Depends on suvar_pkg and the block itself; the filter, normalisation and
// axis remap are predicted in the bench and compared per request.
`timescale 1ns / 100ps
`default_nettype none
module smoothed_unit_vector_axis_remap_unit_tb;
	import suvar_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int SETTLE_CYCLES  = 120;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_SMOOTH;
	logic [16:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] sample_x = '0, sample_y = '0, sample_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] coord_x, coord_y, coord_z;

	smoothed_unit_vector_axis_remap_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z)
	);

	always #5 clk = ~clk;

	// Predicted state of the block.
	logic [16:0] weight_q16 = 17'd65536;
	logic [1:0] coord_mode = CS_IDENTITY;
	logic signed [31:0] filt_axis [3] = '{default: '0};
	logic signed [15:0] unit_axis [3] = '{default: '0};

	sample_t pending_samples [$];
	sample_t expected_coords [$];
	sample_t cur_sample;
	bit req_taken = 0;
	bit no_idle = 0;
	int in_gap = 0;
	int out_hold = 0;
	bit long_hold_done = 0;
	int accepted_in = 0, accepted_out = 0, mismatches = 0;
	int idle_cycles = 0;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] lowpass(logic signed [31:0] prev,
			logic signed [15:0] s, longint w);
		longint acc, r;
		acc = w * (longint'(s) <<< 16) + (longint'(ONE_Q16) - w) * longint'(prev);
		r = (acc + 32768) >>> 16;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic sample_t remap_unit_vector(sample_t s);
		longint w;
		longint unsigned mag [3];
		longint unsigned m, sum, norm, u;
		int k;
		sample_t r;
		w = (weight_q16 > ONE_Q16) ? ONE_Q16 : weight_q16;
		filt_axis[0] = lowpass(filt_axis[0], s.x, w);
		filt_axis[1] = lowpass(filt_axis[1], s.y, w);
		filt_axis[2] = lowpass(filt_axis[2], s.z, w);
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = filt_axis[i] < 0 ? -longint'(filt_axis[i]) : longint'(filt_axis[i]);
			if (mag[i] > m)
				m = mag[i];
		end
		if (m != 0) begin
			k = 0;
			while (k < 31 && (m << (k + 1)) < (64'd1 << 31))
				k++;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				mag[i] <<= k;
				sum += mag[i] * mag[i];
			end
			norm = int_sqrt(sum);
			if (norm != 0)
				for (int i = 0; i < 3; i++) begin
					u = (mag[i] * UNIT_ONE + norm / 2) / norm;
					if (u > UNIT_ONE)
						u = UNIT_ONE;
					unit_axis[i] = filt_axis[i] < 0 ? -u[15:0] : u[15:0];
				end
		end
		case (coord_mode)
			CS_BASIC: r = '{unit_axis[1], unit_axis[0], -unit_axis[2]};
			CS_TILT:  r = '{unit_axis[2], unit_axis[0], unit_axis[1]};
			default:  r = '{unit_axis[0], unit_axis[1], unit_axis[2]};
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (no_idle || p < 65)
			return 0;
		if (p < 93)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// Sender: presents the next pending request after the previous one is taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			req_taken = 0;
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				cur_sample = pending_samples.pop_front();
				sample_x <= cur_sample.x;
				sample_y <= cur_sample.y;
				sample_z <= cur_sample.z;
				in_valid <= 1'b1;
				in_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off once traffic is flowing.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && accepted_out >= 300) begin
				long_hold_done = 1;
				out_hold = 400;
			end
			if (out_hold > 0) begin
				out_hold--;
				out_ready <= 1'b0;
			end else begin
				out_hold = pick_gap();
				out_ready <= (out_hold == 0);
			end
		end
	end

	always @(posedge clk) begin
		sample_t got, want;
		if (in_valid && in_ready) begin
			expected_coords.push_back(remap_unit_vector(cur_sample));
			req_taken = 1;
			accepted_in++;
		end
		if (out_valid && out_ready) begin
			got = '{coord_x, coord_y, coord_z};
			accepted_out++;
			if (expected_coords.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d %0d %0d", got.x, got.y, got.z);
			end else begin
				want = expected_coords.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected %0d %0d %0d, got %0d %0d %0d",
							accepted_out, want.x, want.y, want.z, got.x, got.y, got.z);
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(logic idx, logic [16:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SMOOTH)
			weight_q16 = val;
		else
			coord_mode = val[1:0];
	endtask

	task automatic add_sample(int x, int y, int z);
		sample_t s;
		s.x = x;
		s.y = y;
		s.z = z;
		pending_samples.push_back(s);
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || in_valid || expected_coords.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly a slowly wandering sensor vector with noise, sometimes anything, tiny or zero.
	task automatic add_random(int n);
		int bx, by, bz, amp;
		bx = $signed(16'($urandom));
		by = $signed(16'($urandom));
		bz = $signed(16'($urandom));
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1: add_sample($signed(16'($urandom)), $signed(16'($urandom)),
					$signed(16'($urandom)));
				2: add_sample($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
					$urandom_range(0, 6) - 3);
				3: add_sample(0, 0, 0);
				default: begin
					amp = $urandom_range(0, 3) == 0 ? 4000 : 200;
					bx = $signed(16'(bx + $urandom_range(0, 2 * amp) - amp));
					by = $signed(16'(by + $urandom_range(0, 2 * amp) - amp));
					bz = $signed(16'(bz + $urandom_range(0, 2 * amp) - amp));
					add_sample(bx, by, bz);
				end
			endcase
		end
	endtask

	initial begin
		logic [16:0] weights [6];
		logic [1:0] modes [6];
		weights = '{17'd40000, 17'd131071, 17'd0, 17'd1, 17'd65537, 17'd65536};
		modes = '{CS_BASIC, CS_TILT, CS_IDENTITY, 2'd3, CS_BASIC, CS_TILT};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: a zero vector before anything, extremes, single axes.
		add_sample(0, 0, 0);
		add_sample(32767, 32767, 32767);
		add_sample(-32768, -32768, -32768);
		add_sample(0, 0, 0);
		add_sample(1, 0, 0);
		add_sample(0, -1, 0);
		add_sample(0, 0, 32767);
		add_sample(-32768, 32767, 0);
		add_sample(3, -4, 12);
		add_sample(-1, 1, -1);
		drain();
		write_reg(REG_COORD, CS_BASIC);
		write_reg(REG_SMOOTH, 17'd32768);
		add_sample(32767, -32768, 1);
		add_sample(-32768, 32767, -1);
		add_sample(0, 0, 0);
		add_sample(100, 200, -300);
		add_sample(0, 0, 0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_SMOOTH, weights[ph]);
			write_reg(REG_COORD, modes[ph]);
			no_idle = (ph == 2);
			add_random(220);
			drain();
		end

		if (expected_coords.size() != 0)
			mismatches++;
		$display("Requests in: %0d, results out: %0d, mismatches: %0d.",
			accepted_in, accepted_out, mismatches);
		$display("Covered all coordinate modes, saturating and zero weights, zero vectors.");
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
